// ----- rtl/c2dsp_pkg.sv -----
// shared types, constants and helpers of the streaming 2-d correlation unit
package c2dsp_pkg;

    localparam int MAX_COLS_DEF   = 1024;
    localparam int MAX_ROWS_DEF   = 1024;
    localparam int MAX_KERNEL_DEF = 3;

    localparam int NTAP   = 9;
    localparam int PIX_W  = 16;
    localparam int PROD_W = 2 * PIX_W;
    localparam int ACC_W  = 35;
    localparam int IDX_W  = 11;
    localparam int XW     = 14;
    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    localparam logic [2:0] CFG_KROWS = 3'd0;
    localparam logic [2:0] CFG_KCOLS = 3'd1;
    localparam logic [2:0] CFG_STEP  = 3'd2;
    localparam logic [2:0] CFG_PAD   = 3'd3;
    localparam logic [2:0] CFG_COEFA = 3'd4;
    localparam logic [2:0] CFG_COEFB = 3'd5;
    localparam logic [2:0] CFG_COEFC = 3'd6;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [NTAP-1:0][PIX_W-1:0] t_lanes;

    typedef struct packed {
        t_idx row;
        t_idx col;
        logic last;
        logic done;
    } t_meta;

    typedef struct packed {
        t_idx q;
        logic ok;
    } t_grid;

    // quotient by the stride and whether the position lies on the grid
    function automatic t_grid grid_pos(logic [XW-1:0] x, logic [1:0] s);
        logic [XW+15:0] prod;
        logic [XW-1:0]  q;
        logic           ok;
        t_grid          res;
        prod = '0;
        case (s)
            2'd2: begin
                q  = x >> 1;
                ok = !x[0];
            end
            2'd3: begin
                prod = {16'b0, x} * (XW+16)'(16'hAAAB);
                q    = XW'(prod >> 17);
                ok   = (({2'b0, q} + {1'b0, q, 1'b0}) == {2'b0, x});
            end
            default: begin
                q  = x;
                ok = 1'b1;
            end
        endcase
        res.q  = q[IDX_W-1:0];
        res.ok = ok;
        return res;
    endfunction

endpackage

// ----- rtl/c2dsp_ram.sv -----
// generic single-write, single-read ram with registered read data
module c2dsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/c2dsp_cell.sv -----
// one multiply-accumulate cell of the tap chain
module c2dsp_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [c2dsp_pkg::ACC_W-1:0] i_acc,
    input  c2dsp_pkg::t_lanes                i_pix,
    input  c2dsp_pkg::t_lanes                i_coef,
    input  c2dsp_pkg::t_meta                 i_meta,
    output logic                             o_valid,
    output logic signed [c2dsp_pkg::ACC_W-1:0] o_acc,
    output c2dsp_pkg::t_lanes                o_pix,
    output c2dsp_pkg::t_lanes                o_coef,
    output c2dsp_pkg::t_meta                 o_meta
);

    logic signed [c2dsp_pkg::PROD_W-1:0] prod;
    logic signed [c2dsp_pkg::ACC_W-1:0]  n_acc;
    logic                                r_valid;
    logic signed [c2dsp_pkg::ACC_W-1:0]  r_acc;
    c2dsp_pkg::t_lanes                   r_pix;
    c2dsp_pkg::t_lanes                   r_coef;
    c2dsp_pkg::t_meta                    r_meta;

    assign prod  = $signed(i_pix[0]) * $signed(i_coef[0]);
    assign n_acc = i_acc + c2dsp_pkg::ACC_W'(prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // lanes move down one place so the next cell always works on lane zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_pix  <= i_pix >> c2dsp_pkg::PIX_W;
            r_coef <= i_coef >> c2dsp_pkg::PIX_W;
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_pix   = r_pix;
    assign o_coef  = r_coef;
    assign o_meta  = r_meta;

endmodule

// ----- rtl/conv2d_stride_pad_stream_unit.sv -----
// top level of the streaming 2-d correlation unit with stride and zero padding
// Takes one pixel per clock in raster order and gives one result per clock when neither
// o_stall nor i_stall holds the flow. Each accepted pixel makes zero to four results; a
// pixel that makes more than one result holds the pixel input back, because results
// leave the issue stage one per clock while the chain is not frozen. With padding on,
// every pixel of the last row and the last pixel of every row make up to two results,
// and the last pixel of the last row up to four. After the line buffer read, a result
// passes the issue stage, nine multiply-accumulate cells and the output register.
// The line buffer is two rams of MAX_COLS entries with no clearing pass after reset.
module conv2d_stride_pad_stream_unit #(
    parameter int MAX_COLS   = c2dsp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = c2dsp_pkg::MAX_ROWS_DEF,
    parameter int MAX_KERNEL = c2dsp_pkg::MAX_KERNEL_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [c2dsp_pkg::PIX_W-1:0]    i_pixel,
    input  logic                                  i_end_of_row,
    input  logic                                  i_in_final_row,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [c2dsp_pkg::ACC_W-1:0]    o_value,
    output logic [c2dsp_pkg::IDX_W-1:0]           o_out_row,
    output logic [c2dsp_pkg::IDX_W-1:0]           o_out_col,
    output logic                                  o_last_of_run,
    output logic                                  o_frame_done,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [c2dsp_pkg::CFG_AW-1:0]          paddr,
    input  logic [c2dsp_pkg::CFG_DW-1:0]          pwdata,
    output logic [c2dsp_pkg::CFG_DW-1:0]          prdata,
    output logic                                  pready
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int XW = c2dsp_pkg::XW;
    localparam int NTAP = c2dsp_pkg::NTAP;
    localparam int PW = c2dsp_pkg::PIX_W;
    localparam int AW = c2dsp_pkg::ACC_W;
    localparam int IW = c2dsp_pkg::IDX_W;

    // configuration registers
    logic [1:0]  r_krows, r_kcols, r_step;
    logic        r_pad;
    logic [63:0] r_coeff_a, r_coeff_b;
    logic [15:0] r_coeff_c;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krows   <= 2'd3;
            r_kcols   <= 2'd3;
            r_step    <= 2'd1;
            r_pad     <= 1'b0;
            r_coeff_a <= '0;
            r_coeff_b <= '0;
            r_coeff_c <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                c2dsp_pkg::CFG_KROWS: r_krows   <= pwdata[1:0];
                c2dsp_pkg::CFG_KCOLS: r_kcols   <= pwdata[1:0];
                c2dsp_pkg::CFG_STEP:  r_step    <= pwdata[1:0];
                c2dsp_pkg::CFG_PAD:   r_pad     <= pwdata[0];
                c2dsp_pkg::CFG_COEFA: r_coeff_a <= pwdata;
                c2dsp_pkg::CFG_COEFB: r_coeff_b <= pwdata;
                c2dsp_pkg::CFG_COEFC: r_coeff_c <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            c2dsp_pkg::CFG_KROWS: prdata = {62'b0, r_krows};
            c2dsp_pkg::CFG_KCOLS: prdata = {62'b0, r_kcols};
            c2dsp_pkg::CFG_STEP:  prdata = {62'b0, r_step};
            c2dsp_pkg::CFG_PAD:   prdata = {63'b0, r_pad};
            c2dsp_pkg::CFG_COEFA: prdata = r_coeff_a;
            c2dsp_pkg::CFG_COEFB: prdata = r_coeff_b;
            c2dsp_pkg::CFG_COEFC: prdata = {48'b0, r_coeff_c};
            default:              prdata = '0;
        endcase
    end

    logic [1:0] kh, kw, stp;
    assign kh  = (r_krows == 2'd0) ? 2'd1 :
                 (r_krows > 2'(MAX_KERNEL)) ? 2'(MAX_KERNEL) : r_krows;
    assign kw  = (r_kcols == 2'd0) ? 2'd1 :
                 (r_kcols > 2'(MAX_KERNEL)) ? 2'(MAX_KERNEL) : r_kcols;
    assign stp = (r_step == 2'd0) ? 2'd1 : r_step;

    // flow control
    logic adv, accept, b_move, c_ready, fire;
    logic r_bv, r_sv, r_ov;
    logic [3:0] r_pend;

    assign adv     = !r_sv;
    assign c_ready = $onehot0(r_pend);
    assign b_move  = adv && r_bv && c_ready;
    assign o_stall = !(adv && (!r_bv || c_ready));
    assign accept  = i_valid && !o_stall;
    assign fire    = adv && (|r_pend);

    // request position and result candidates
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [IW-1:0] r_rwidth;
    logic          eor, fin, wknown;
    logic [XW-1:0] width;
    logic [XW-1:0] rbase [2];
    logic [XW-1:0] cbase [2];
    c2dsp_pkg::t_grid rg [2];
    c2dsp_pkg::t_grid cg [2];
    logic [1:0]    rv, cv, rdone, cdone;
    logic [3:0]    n_pend, n_done;
    logic [1:0]    rlo, clo;

    assign eor    = i_end_of_row || (r_col == CW'(MAX_COLS - 1));
    assign fin    = i_in_final_row || (r_row == RW'(MAX_ROWS - 1));
    assign wknown = eor || (r_row != '0);
    assign width  = eor ? (XW'(r_col) + XW'(1)) : XW'(r_rwidth);
    assign rlo    = (r_row > RW'(1)) ? 2'd2 : 2'(r_row);
    assign clo    = (r_col > CW'(1)) ? 2'd2 : 2'(r_col);

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            rbase[d] = XW'(r_row) + XW'(r_pad) + XW'(d) + XW'(1);
            cbase[d] = XW'(r_col) + XW'(r_pad) + XW'(d) + XW'(1);
            rg[d]    = c2dsp_pkg::grid_pos(rbase[d] - XW'(kh), stp);
            cg[d]    = c2dsp_pkg::grid_pos(cbase[d] - XW'(kw), stp);
            rv[d]    = (rbase[d] >= XW'(kh)) && rg[d].ok;
            cv[d]    = (cbase[d] >= XW'(kw)) && cg[d].ok;
            rdone[d] = (3'(d) + 3'(stp)) > 3'(r_pad);
            cdone[d] = (XW'(r_col) + XW'(d) + XW'(stp) + XW'(1)) > (width + XW'(r_pad));
        end
        rv[1] = rv[1] && fin && r_pad;
        cv[1] = cv[1] && eor && r_pad;
        for (int j = 0; j < 4; j++) begin
            n_pend[j] = rv[j / 2] && cv[j % 2];
            n_done[j] = fin && wknown && rdone[j / 2] && cdone[j % 2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_rwidth <= '0;
        end else if (accept) begin
            if (eor) begin
                r_rwidth <= IW'(XW'(r_col) + XW'(1));
                r_col    <= '0;
                r_row    <= fin ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line buffer, one ram per row slot
    logic [PW-1:0] rd0, rd1;

    c2dsp_ram #(.WIDTH(PW), .DEPTH(MAX_COLS)) u_ls0 (
        .i_clk   (i_clk),
        .i_we    (accept && !r_row[0]),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd0)
    );

    c2dsp_ram #(.WIDTH(PW), .DEPTH(MAX_COLS)) u_ls1 (
        .i_clk   (i_clk),
        .i_we    (accept && r_row[0]),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd1)
    );

    // read stage
    logic [PW-1:0] r_bpix;
    logic          r_brbit;
    logic [1:0]    r_brlo, r_bclo;
    logic [3:0]    r_bpend, r_bdone;
    logic [IW-1:0] r_browq [2];
    logic [IW-1:0] r_bcolq [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (accept) begin
            r_bv <= 1'b1;
        end else if (b_move) begin
            r_bv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bpix     <= i_pixel;
            r_brbit    <= r_row[0];
            r_brlo     <= rlo;
            r_bclo     <= clo;
            r_bpend    <= n_pend;
            r_bdone    <= n_done;
            r_browq[0] <= rg[0].q;
            r_browq[1] <= rg[1].q;
            r_bcolq[0] <= cg[0].q;
            r_bcolq[1] <= cg[1].q;
        end
    end

    // window and issue stage
    c2dsp_pkg::t_lanes r_win;
    logic [1:0]    r_crlo, r_cclo;
    logic [3:0]    r_cdone;
    logic [IW-1:0] r_crowq [2];
    logic [IW-1:0] r_ccolq [2];
    logic [1:0]    sel;
    logic [3:0]    rest;

    assign sel  = r_pend[0] ? 2'd0 : r_pend[1] ? 2'd1 : r_pend[2] ? 2'd2 : 2'd3;
    assign rest = r_pend & ~(4'b0001 << sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_win  <= '0;
        end else if (b_move) begin
            r_pend <= r_bpend;
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= r_brbit ? rd1 : rd0;
            r_win[5] <= r_brbit ? rd0 : rd1;
            r_win[8] <= r_bpix;
        end else if (fire) begin
            r_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_crlo     <= r_brlo;
            r_cclo     <= r_bclo;
            r_cdone    <= r_bdone;
            r_crowq[0] <= r_browq[0];
            r_crowq[1] <= r_browq[1];
            r_ccolq[0] <= r_bcolq[0];
            r_ccolq[1] <= r_bcolq[1];
        end
    end

    c2dsp_pkg::t_lanes coefs, job_pix, job_coef;
    c2dsp_pkg::t_meta  job_meta;

    assign coefs = c2dsp_pkg::t_lanes'({r_coeff_c, r_coeff_b, r_coeff_a});

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            logic       in_row, in_col;
            logic [2:0] mi, nj;
            logic [3:0] k;
            assign in_row = ((3'(gi) + 3'(kh)) >= (3'd3 + 3'(sel[1])))
                         && ((3'(gi) + 3'(r_crlo)) >= 3'd2);
            assign in_col = ((3'(gj) + 3'(kw)) >= (3'd3 + 3'(sel[0])))
                         && ((3'(gj) + 3'(r_cclo)) >= 3'd2);
            assign mi = 3'(gi) + 3'(kh) - 3'd3 - 3'(sel[1]);
            assign nj = 3'(gj) + 3'(kw) - 3'd3 - 3'(sel[0]);
            assign k  = {2'b0, mi[1:0]} + {1'b0, mi[1:0], 1'b0} + {2'b0, nj[1:0]};
            assign job_pix[gi*3+gj]  = (in_row && in_col) ? r_win[gi*3+gj] : '0;
            assign job_coef[gi*3+gj] = (in_row && in_col) ? coefs[k] : '0;
        end
    end

    assign job_meta.row  = r_crowq[sel[1]];
    assign job_meta.col  = r_ccolq[sel[0]];
    assign job_meta.last = (rest == 4'b0000);
    assign job_meta.done = r_cdone[sel];

    // multiply-accumulate chain
    logic                 ch_v    [NTAP+1];
    logic signed [AW-1:0] ch_acc  [NTAP+1];
    c2dsp_pkg::t_lanes    ch_pix  [NTAP+1];
    c2dsp_pkg::t_lanes    ch_coef [NTAP+1];
    c2dsp_pkg::t_meta     ch_meta [NTAP+1];

    assign ch_v[0]    = fire;
    assign ch_acc[0]  = '0;
    assign ch_pix[0]  = job_pix;
    assign ch_coef[0] = job_coef;
    assign ch_meta[0] = job_meta;

    for (genvar gc = 0; gc < NTAP; gc++) begin : g_cell
        c2dsp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (ch_v[gc]),
            .i_acc   (ch_acc[gc]),
            .i_pix   (ch_pix[gc]),
            .i_coef  (ch_coef[gc]),
            .i_meta  (ch_meta[gc]),
            .o_valid (ch_v[gc+1]),
            .o_acc   (ch_acc[gc+1]),
            .o_pix   (ch_pix[gc+1]),
            .o_coef  (ch_coef[gc+1]),
            .o_meta  (ch_meta[gc+1])
        );
    end

    // output register with skid stage
    logic signed [AW-1:0] r_oval, r_sval;
    c2dsp_pkg::t_meta     r_ometa, r_smeta;
    logic                 tail_v;

    assign tail_v = adv && ch_v[NTAP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= tail_v;
            end
        end else if (tail_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            if (r_sv) begin
                r_oval  <= r_sval;
                r_ometa <= r_smeta;
            end else if (tail_v) begin
                r_oval  <= ch_acc[NTAP];
                r_ometa <= ch_meta[NTAP];
            end
        end else if (tail_v) begin
            r_sval  <= ch_acc[NTAP];
            r_smeta <= ch_meta[NTAP];
        end
    end

    assign o_valid       = r_ov;
    assign o_value       = r_oval;
    assign o_out_row     = r_ometa.row;
    assign o_out_col     = r_ometa.col;
    assign o_last_of_run = r_ometa.last;
    assign o_frame_done  = r_ometa.done;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry without output entry");

    a_no_accept_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> !accept)
        else $error("pixel taken while chain is frozen");

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && job_meta.last) |-> $onehot(r_pend))
        else $error("last flag with further results pending");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_move |=> ($past(r_bpend) == r_pend))
        else $error("issue stage overwritten");

endmodule

// ----- sim/conv2d_stride_pad_stream_unit_test.sv -----
// testbench of the streaming 2-d correlation unit with stride and zero padding
`timescale 1ns / 1ps

module conv2d_stride_pad_stream_unit_test;

    typedef struct packed {
        bit [c2dsp_pkg::ACC_W-1:0] value;
        bit [c2dsp_pkg::IDX_W-1:0] row;
        bit [c2dsp_pkg::IDX_W-1:0] col;
        bit                        last;
        bit                        done;
    } t_conv_result;

    class t_conv_scoreboard;
        bit [1:0]       krows, kcols, stride;
        bit             pad;
        bit [63:0]      taps_a, taps_b;
        bit [15:0]      taps_c;
        bit [15:0]      lines [2][1024];
        bit [15:0]      win [9];
        int             col_cnt, row_cnt, last_width;
        t_conv_result   pending_results [$];
        int             mismatches;

        function new();
            krows = 3; kcols = 3; stride = 1; pad = 0;
            taps_a = '0; taps_b = '0; taps_c = '0;
            foreach (lines[i, j]) lines[i][j] = '0;
            foreach (win[i]) win[i] = '0;
            col_cnt = 0; row_cnt = 0; last_width = 0; mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, bit [63:0] v);
            case (idx)
                c2dsp_pkg::CFG_KROWS: krows = v[1:0];
                c2dsp_pkg::CFG_KCOLS: kcols = v[1:0];
                c2dsp_pkg::CFG_STEP:  stride = v[1:0];
                c2dsp_pkg::CFG_PAD:   pad = v[0];
                c2dsp_pkg::CFG_COEFA: taps_a = v;
                c2dsp_pkg::CFG_COEFB: taps_b = v;
                c2dsp_pkg::CFG_COEFC: taps_c = v[15:0];
                default: ;
            endcase
        endfunction

        function longint tap(int k);
            bit [143:0] all;
            all = {taps_c, taps_b, taps_a};
            return longint'($signed(all[16*k +: 16]));
        endfunction

        function longint window_sum(longint rb, longint cb, longint kh, longint kw,
                                    longint p, longint r, longint c);
            longint acc, rr, cr, wr, wc;
            acc = 0;
            for (longint m = 0; m < kh; m++) begin
                for (longint n = 0; n < kw; n++) begin
                    rr = rb - kh + 1 + m - p;
                    cr = cb - kw + 1 + n - p;
                    wr = 2 - (r - rr);
                    wc = 2 - (c - cr);
                    if (rr < 0 || rr > r || cr < 0 || cr > c) continue;
                    if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
                    acc += longint'($signed(win[wr*3 + wc])) * tap(int'(m*3 + n));
                end
            end
            return acc;
        endfunction

        function void note(bit [15:0] pix, bit eor_in, bit fin_in);
            longint kh, kw, s, p, rb, cb, top, left, width;
            longint rows [2], cols [2];
            int nr, nc, c, r, first;
            bit eor, fin, known, done;
            t_conv_result res;
            kh = (krows == 0) ? 1 : krows;
            kw = (kcols == 0) ? 1 : kcols;
            s = (stride == 0) ? 1 : stride;
            p = pad;
            c = col_cnt % 1024;
            r = row_cnt % 1024;
            eor = eor_in || c == 1023;
            fin = fin_in || r == 1023;
            for (int i = 0; i < 3; i++) begin
                win[i*3]     = win[i*3 + 1];
                win[i*3 + 1] = win[i*3 + 2];
            end
            win[2] = lines[r & 1][c];
            win[5] = lines[(r + 1) & 1][c];
            win[8] = pix;
            lines[r & 1][c] = pix;
            nr = 0; nc = 0;
            rows[nr++] = r + p;
            if (fin && p) rows[nr++] = r + p + 1;
            cols[nc++] = c + p;
            if (eor && p) cols[nc++] = c + p + 1;
            known = eor || r > 0;
            width = eor ? c + 1 : last_width;
            first = pending_results.size();
            for (int a = 0; a < nr; a++) begin
                for (int b = 0; b < nc; b++) begin
                    rb = rows[a]; cb = cols[b];
                    top = rb - kh + 1; left = cb - kw + 1;
                    if (top < 0 || left < 0 || top % s != 0 || left % s != 0) continue;
                    done = fin && known && rb + s > r + 2*p && cb + s > width - 1 + 2*p;
                    res.value = c2dsp_pkg::ACC_W'(window_sum(rb, cb, kh, kw, p, r, c));
                    res.row = c2dsp_pkg::IDX_W'(top / s);
                    res.col = c2dsp_pkg::IDX_W'(left / s);
                    res.last = 0;
                    res.done = done;
                    pending_results.push_back(res);
                end
            end
            if (pending_results.size() > first)
                pending_results[pending_results.size()-1].last = 1;
            if (eor) begin
                last_width = (c + 1) & 11'h7ff;
                col_cnt = 0;
                row_cnt = fin ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check(t_conv_result got);
            t_conv_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h row=%0d col=%0d",
                             got.value, got.row, got.col);
                return;
            end
            want = pending_results.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want %h r%0d c%0d l%0d d%0d got %h r%0d c%0d l%0d d%0d",
                             want.value, want.row, want.col, want.last, want.done,
                             got.value, got.row, got.col, got.last, got.done);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall, i_stall, o_valid;
    logic signed [15:0] i_pixel;
    logic               i_end_of_row, i_in_final_row;
    logic signed [c2dsp_pkg::ACC_W-1:0] o_value;
    logic [c2dsp_pkg::IDX_W-1:0]        o_out_row, o_out_col;
    logic               o_last_of_run, o_frame_done;
    logic               psel, penable, pwrite, pready;
    logic [c2dsp_pkg::CFG_AW-1:0]       paddr;
    logic [c2dsp_pkg::CFG_DW-1:0]       pwdata, prdata;

    t_conv_scoreboard   sb;
    bit                 calm;
    bit                 hold;
    t_conv_result       seen;

    conv2d_stride_pad_stream_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pixel(i_pixel), .i_end_of_row(i_end_of_row), .i_in_final_row(i_in_final_row),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_value(o_value), .o_out_row(o_out_row), .o_out_col(o_out_col),
        .o_last_of_run(o_last_of_run), .o_frame_done(o_frame_done),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200_000;
        $display("FAIL");
        $finish;
    end

    always @(negedge i_clk)
        i_stall <= hold || (!calm && $urandom_range(99) < 22);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen.value = o_value;
            seen.row = o_out_row;
            seen.col = o_out_col;
            seen.last = o_last_of_run;
            seen.done = o_frame_done;
            sb.check(seen);
        end
    end

    function automatic bit [15:0] rand_pixel();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] rand_tap();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, bit [63:0] v);
        psel = 1; penable = 0; pwrite = 1;
        paddr = {idx, 3'b000}; pwdata = v;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_shape(bit [1:0] kr, bit [1:0] kc, bit [1:0] s, bit p);
        write_reg(c2dsp_pkg::CFG_KROWS, 64'(kr));
        write_reg(c2dsp_pkg::CFG_KCOLS, 64'(kc));
        write_reg(c2dsp_pkg::CFG_STEP, 64'(s));
        write_reg(c2dsp_pkg::CFG_PAD, 64'(p));
        write_reg(c2dsp_pkg::CFG_COEFA, {rand_tap(), rand_tap(), rand_tap(), rand_tap()});
        write_reg(c2dsp_pkg::CFG_COEFB, {rand_tap(), rand_tap(), rand_tap(), rand_tap()});
        write_reg(c2dsp_pkg::CFG_COEFC, 64'(rand_tap()));
    endtask

    task automatic send_pixel(bit [15:0] pix, bit eor, bit fin);
        while (!calm && $urandom_range(99) < 22) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1; i_pixel = pix; i_end_of_row = eor; i_in_final_row = fin;
        do @(posedge i_clk); while (o_stall);
        sb.note(pix, eor, fin);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic send_frame(int h, int w, bit ragged);
        int rw;
        for (int r = 0; r < h; r++) begin
            rw = ragged ? $urandom_range(1, 12) : w;
            for (int c = 0; c < rw; c++)
                send_pixel(rand_pixel(), c == rw - 1, r == h - 1);
        end
    endtask

    task automatic drain();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n = 0; i_valid = 0; i_pixel = 0; i_end_of_row = 0; i_in_final_row = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        calm = 0; hold = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // two rows of sixteen under a long receiver hold; writes the first sixteen line store columns
        set_shape(3, 3, 1, 1);
        fork
            begin
                repeat (10) @(posedge i_clk);
                hold = 1;
                repeat (100) @(posedge i_clk);
                hold = 0;
            end
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < 16; c++)
                    send_pixel(rand_pixel(), c == 15, r == 1);
        join
        drain();

        // single pixel, single row and extreme pixels
        set_shape(3, 3, 3, 1);
        send_pixel(16'h8000, 1, 1);
        send_frame(1, 4, 0);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((r + c) % 2 ? 16'h7fff : 16'h8000, c == 2, r == 2);
        drain();

        // random frames under several shapes, out-of-range kernel and stride among them
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            case (ph)
                0: set_shape(1, 1, 1, 0);
                1: set_shape(3, 3, 3, 0);
                2: set_shape(0, 0, 0, 1);
                3: set_shape(3, 3, 1, 1);
                4: set_shape(2, 3, 2, 1);
                default: set_shape(2'($urandom_range(3)), 2'($urandom_range(3)),
                                   2'($urandom_range(3)), 1'($urandom_range(1)));
            endcase
            write_reg(c2dsp_pkg::CFG_COEFA, 64'h8000_7fff_8000_7fff);
            if (ph != 1)
                write_reg(c2dsp_pkg::CFG_COEFA,
                          {rand_tap(), rand_tap(), rand_tap(), rand_tap()});
            send_frame($urandom_range(1, 4), $urandom_range(1, 6), 0);
            send_frame($urandom_range(1, 3), 0, 1);
            drain();
        end
        calm = 0;

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/c2dsp_pkg.sv
rtl/c2dsp_ram.sv
rtl/c2dsp_cell.sv
rtl/conv2d_stride_pad_stream_unit.sv
sim/conv2d_stride_pad_stream_unit_test.sv
